// File: hw/rtl/sfr_pkg.sv
package sfr_pkg;

	localparam int ActionW = 4;

	localparam logic [ActionW-1:0] ACT_LOAD  = 4'd0;
	localparam logic [ActionW-1:0] ACT_U8    = 4'd1;
	localparam logic [ActionW-1:0] ACT_U16   = 4'd2;
	localparam logic [ActionW-1:0] ACT_U32   = 4'd3;
	localparam logic [ActionW-1:0] ACT_BITS  = 4'd4;
	localparam logic [ActionW-1:0] ACT_S24   = 4'd5;
	localparam logic [ActionW-1:0] ACT_VU32  = 4'd6;
	localparam logic [ActionW-1:0] ACT_VS32  = 4'd7;
	localparam logic [ActionW-1:0] ACT_ALIGN = 4'd8;
	localparam logic [ActionW-1:0] ACT_RAW64 = 4'd9;

	localparam logic [5:0] MaxBits    = 6'd32;
	localparam logic [2:0] VarLastIdx = 3'd4;
	localparam logic [2:0] S24SignIdx = 3'd2;

	typedef enum logic [1:0] {
		ACC_LE,
		ACC_VAR,
		ACC_BITS
	} acc_mode_t;

	typedef struct packed {
		logic      clear;
		logic      step;
		acc_mode_t mode;
		logic [2:0] idx;
		logic [2:0] bitpos;
		logic [3:0] take;
		logic      sext;
	} acc_ctl_t;

endpackage

// File: hw/rtl/sfr_mem.sv
module sfr_mem
	import sfr_pkg::*;
#(
	parameter int Depth = 4096,
	parameter int AddrW = 12
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [7:0]       wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [7:0]       rdata
);

	logic [7:0] mem_q [Depth];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/sfr_acc.sv
module sfr_acc
	import sfr_pkg::*;
(
	input  logic        clk,
	input  acc_ctl_t    ctl,
	input  logic [7:0]  data,
	output logic [63:0] acc
);

	logic [63:0] acc_q;
	logic [63:0] acc_d;
	logic [31:0] acc32;
	logic [5:0]  shamt;
	logic [3:0]  sh;
	logic [7:0]  field;

	always_comb begin
		acc_d = acc_q;
		acc32 = acc_q[31:0];
		shamt = 6'({ctl.idx, 3'b000}) - 6'(ctl.idx);
		sh    = 4'd8 - {1'b0, ctl.bitpos} - ctl.take;
		field = (data >> sh) & ((8'h1 << ctl.take) - 8'h1);
		unique case (ctl.mode)
			ACC_LE: begin
				acc_d = acc_q | (64'(data) << {ctl.idx, 3'b000});
				if (ctl.sext) begin
					acc_d[31:24] = 8'hff;
				end
			end
			ACC_VAR: begin
				acc32 = acc_q[31:0] | (32'(data[6:0]) << shamt);
				if (ctl.sext) begin
					acc32 = acc32 | (32'hffffffff << (shamt + 6'd7));
				end
				acc_d = {32'd0, acc32};
			end
			ACC_BITS: begin
				acc32 = (acc_q[31:0] << ctl.take) | 32'(field);
				acc_d = {32'd0, acc32};
			end
			default: begin
				acc_d = acc_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= acc_d;
		end
	end

	assign acc = acc_q;

endmodule

// File: hw/rtl/swf_field_reader.sv
// Byte stream reader: load bytes with action 0, then pull little-endian integers, MSB-first
// bit fields, s24, 7-bit varints or raw 64-bit words from the cursor. One transaction is
// handled at a time and req_stall stays high until its result is registered. The buffer has
// a single read port giving one byte per cycle. Each transaction goes from ST_PREP through
// ST_BYTES, ST_BITS or ST_ROUND as its action needs (a load or an unknown code skips them)
// to ST_DONE. A new transaction can be accepted while the previous result still waits on
// rsp_stall.
module swf_field_reader
	import sfr_pkg::*;
#(
	parameter int BUFFER_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [3:0]  action,
	input  logic [7:0]  load_value,
	input  logic [5:0]  bit_count,
	input  logic [1:0]  align_log2,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [63:0] value,
	output logic        status,
	output logic [12:0] cursor_byte,
	output logic [2:0]  cursor_bit
);

	localparam int AddrW = $clog2(BUFFER_DEPTH);
	localparam int PosW  = $clog2(BUFFER_DEPTH + 1);
	localparam logic [PosW-1:0] DepthP  = PosW'(BUFFER_DEPTH);
	localparam logic [PosW:0]   DepthP1 = (PosW + 1)'(BUFFER_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ROUND,
		ST_BYTES,
		ST_BITS,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [ActionW-1:0]  op_q;
	logic [7:0]          load_q;
	logic [5:0]          nbits_q;
	logic [1:0]          alog_q;
	logic [PosW-1:0]     len_q;
	logic [PosW-1:0]     pos_q;
	logic [2:0]          bit_q;
	logic [2:0]          idx_q;
	logic [2:0]          lastidx_q;
	logic [5:0]          rem_q;
	logic                ov_q;
	logic                rvld_q;
	logic [63:0]         value_q;
	logic                status_q;
	logic [12:0]         cbyte_q;
	logic [2:0]          cbit_q;

	logic [7:0]      rd_data;
	logic [7:0]      rbyte;
	logic            miss;
	logic [PosW-1:0] pos_inc;
	logic [PosW-1:0] pos_al;
	logic [3:0]      room;
	logic [3:0]      take;
	logic [3:0]      bsum;
	logic [PosW-1:0] bits_pos_n;
	logic [2:0]      bits_bit_n;
	logic            var_last;
	logic            le_last;
	logic [2:0]      m3;
	logic [PosW:0]   rsum;
	logic [PosW:0]   rnd;
	logic [PosW-1:0] pos_rnd;
	logic [PosW-1:0] rd_pos;
	logic            is_var;
	logic            mem_we;
	acc_ctl_t        acc_ctl;
	logic [63:0]     acc;

	function automatic logic [PosW-1:0] inc_sat(input logic [PosW-1:0] p);
		inc_sat = (p == DepthP) ? p : p + PosW'(1);
	endfunction

	always_comb begin
		miss     = !(pos_q < len_q);
		rbyte    = miss ? 8'd0 : rd_data;
		pos_inc  = inc_sat(pos_q);
		pos_al   = (bit_q != 3'd0) ? pos_inc : pos_q;
		room     = 4'd8 - {1'b0, bit_q};
		take     = (rem_q < {2'b00, room}) ? rem_q[3:0] : room;
		bsum     = {1'b0, bit_q} + take;
		bits_pos_n = bsum[3] ? pos_inc : pos_q;
		bits_bit_n = (bsum[3] || bits_pos_n == DepthP) ? 3'd0 : bsum[2:0];
		is_var   = (op_q == ACT_VU32) || (op_q == ACT_VS32);
		var_last = !rbyte[7] || (idx_q == VarLastIdx);
		le_last  = (idx_q == lastidx_q);
		m3       = 3'((4'd1 << alog_q) - 4'd1);
		rsum     = {1'b0, pos_q} + (PosW + 1)'(m3);
		rnd      = rsum & ~((PosW + 1)'(m3));
		pos_rnd  = (rnd >= DepthP1) ? DepthP : rnd[PosW-1:0];
		mem_we   = (state_q == ST_PREP) && (op_q == ACT_LOAD) && (len_q < DepthP);

		unique case (state_q)
			ST_PREP:  rd_pos = (op_q == ACT_BITS) ? pos_q : pos_al;
			ST_BYTES: rd_pos = pos_inc;
			ST_BITS:  rd_pos = bits_pos_n;
			default:  rd_pos = pos_q;
		endcase

		acc_ctl.clear  = (state_q == ST_PREP);
		acc_ctl.step   = (state_q == ST_BYTES) || (state_q == ST_BITS);
		acc_ctl.idx    = idx_q;
		acc_ctl.bitpos = bit_q;
		acc_ctl.take   = take;
		if (op_q == ACT_BITS) begin
			acc_ctl.mode = ACC_BITS;
		end else if (is_var) begin
			acc_ctl.mode = ACC_VAR;
		end else begin
			acc_ctl.mode = ACC_LE;
		end
		acc_ctl.sext = ((op_q == ACT_S24) && (idx_q == S24SignIdx) && rbyte[7])
			|| ((op_q == ACT_VS32) && var_last && (idx_q < VarLastIdx) && rbyte[6]);
	end

	sfr_mem #(
		.Depth (BUFFER_DEPTH),
		.AddrW (AddrW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (len_q[AddrW-1:0]),
		.wdata (load_q),
		.raddr (rd_pos[AddrW-1:0]),
		.rdata (rd_data)
	);

	sfr_acc u_acc (
		.clk  (clk),
		.ctl  (acc_ctl),
		.data (rbyte),
		.acc  (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= ACT_LOAD;
			load_q    <= '0;
			nbits_q   <= '0;
			alog_q    <= '0;
			len_q     <= '0;
			pos_q     <= '0;
			bit_q     <= '0;
			idx_q     <= '0;
			lastidx_q <= '0;
			rem_q     <= '0;
			ov_q      <= 1'b0;
			rvld_q    <= 1'b0;
			value_q   <= '0;
			status_q  <= 1'b0;
			cbyte_q   <= '0;
			cbit_q    <= '0;
		end else begin
			if (rvld_q && !rsp_stall && (state_q != ST_DONE)) begin
				rvld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q    <= action;
						load_q  <= load_value;
						nbits_q <= (bit_count > MaxBits) ? MaxBits : bit_count;
						alog_q  <= align_log2;
						ov_q    <= 1'b0;
						idx_q   <= '0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					unique case (op_q)
						ACT_LOAD: begin
							if (len_q < DepthP) begin
								len_q <= len_q + PosW'(1);
							end else begin
								ov_q <= 1'b1;
							end
							state_q <= ST_DONE;
						end
						ACT_U8, ACT_U16, ACT_U32, ACT_S24, ACT_RAW64,
						ACT_VU32, ACT_VS32: begin
							pos_q   <= pos_al;
							bit_q   <= 3'd0;
							state_q <= ST_BYTES;
							unique case (op_q)
								ACT_U8:  lastidx_q <= 3'd0;
								ACT_U16: lastidx_q <= 3'd1;
								ACT_S24: lastidx_q <= 3'd2;
								ACT_U32: lastidx_q <= 3'd3;
								default: lastidx_q <= 3'd7;
							endcase
						end
						ACT_BITS: begin
							rem_q   <= nbits_q;
							state_q <= (nbits_q == 6'd0) ? ST_DONE : ST_BITS;
						end
						ACT_ALIGN: begin
							pos_q   <= pos_al;
							bit_q   <= 3'd0;
							state_q <= ST_ROUND;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_ROUND: begin
					pos_q   <= pos_rnd;
					state_q <= ST_DONE;
				end
				ST_BYTES: begin
					ov_q  <= ov_q | miss;
					pos_q <= pos_inc;
					idx_q <= idx_q + 3'd1;
					if (is_var ? var_last : le_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_BITS: begin
					ov_q  <= ov_q | miss;
					pos_q <= bits_pos_n;
					bit_q <= bits_bit_n;
					rem_q <= rem_q - 6'(take);
					if (rem_q == 6'(take)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rvld_q || !rsp_stall) begin
						value_q  <= acc;
						status_q <= ov_q;
						cbyte_q  <= 13'(pos_q);
						cbit_q   <= bit_q;
						rvld_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall   = (state_q != ST_IDLE);
	assign rsp_valid   = rvld_q;
	assign value       = value_q;
	assign status      = status_q;
	assign cursor_byte = cbyte_q;
	assign cursor_bit  = cbit_q;

endmodule
